>>> src/exponential_search_sorted_core_macros.svh
// Assertion macros for the exponential search core.
// Used by the top level only; expects a clock named clock and a reset named reset.
`ifndef EXPONENTIAL_SEARCH_SORTED_CORE_MACROS_SVH
`define EXPONENTIAL_SEARCH_SORTED_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ESS_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("exponential search core: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ESS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("exponential search core: next-cycle check failed");

`endif

>>> src/ess_pkg.sv
// Shared types and constants of the exponential search core.
// No dependencies; imported by ess_search and the top level, not by ess_ram.
`default_nettype none

package ess_pkg;

   localparam int STORE_DEPTH = 1024;
   localparam int WORD_W      = 32;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int BOUND_W     = ADDR_W + 1;
   localparam int COUNT_W     = 11;
   localparam int INDEX_W     = 10;
   localparam int POS_W       = 10;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic [BOUND_W-1:0]       bound_type;
   typedef logic [COUNT_W-1:0]       count_type;
   typedef logic [INDEX_W-1:0]       index_type;
   typedef logic [POS_W-1:0]         pos_type;

   typedef struct packed {
      logic     en;
      addr_type addr;
   } rd_req_type;

   typedef struct packed {
      logic    valid;
      logic    found;
      pos_type position;
   } rsp_type;

endpackage

`default_nettype wire

>>> src/ess_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; no package needed.
`default_nettype none

module ess_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> src/ess_search.sv
// Search sequencer: gallops, then bisects, issuing one store read per cycle.
// Depends on ess_pkg; reads the store through ess_ram's registered port.
`default_nettype none

module ess_search (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                search_start,
   input  wire ess_pkg::word_type   search_key,
   input  wire ess_pkg::count_type  element_count,
   input  wire ess_pkg::word_type   rd_data,
   output ess_pkg::rd_req_type      rd_req,
   output logic                     busy,
   output ess_pkg::rsp_type         rsp
);

   import ess_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_GALLOP, ST_BCHECK} state_type;

   state_type state_ff, state_in;
   bound_type lo_ff, lo_in;
   addr_type  hi_ff, hi_in;
   addr_type  mid_ff, mid_in;
   addr_type  last_ff, last_in;
   word_type  key_ff, key_in;
   rsp_type   rsp_ff, rsp_in;

   bound_type n_eff;
   addr_type  last_w;
   bound_type nlo;
   addr_type  nhi;
   logic      stop;

   function automatic addr_type mid_of(input bound_type lo, input addr_type hi);
      bound_type span;
      span   = BOUND_W'(hi) - lo;
      mid_of = ADDR_W'(lo + (span >> 1));
   endfunction

   // Counts beyond the store size behave as a full store.
   always_comb begin
      if (32'(element_count) > 32'(STORE_DEPTH)) begin
         n_eff = BOUND_W'(STORE_DEPTH);
      end else begin
         n_eff = BOUND_W'(element_count);
      end
      last_w = ADDR_W'(n_eff - 1'b1);
   end

   always_comb begin
      state_in = state_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      last_in  = last_ff;
      key_in   = key_ff;
      rsp_in   = '{valid: 1'b0, found: 1'b0, position: '0};
      rd_req   = '{en: 1'b0, addr: mid_ff};
      nlo      = lo_ff;
      nhi      = hi_ff;
      stop     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (search_start) begin
               key_in = search_key;
               if (n_eff == '0) begin
                  rsp_in.valid = 1'b1;
               end else begin
                  last_in     = last_w;
                  lo_in       = '0;
                  hi_in       = (last_w == '0) ? '0 : ADDR_W'(1);
                  rd_req.en   = 1'b1;
                  rd_req.addr = '0;
                  state_in    = ST_GALLOP;
               end
            end
         end
         ST_GALLOP: begin
            // rd_data holds element 0 on the first galloping probe, then the element at the current upper bound.
            if ((rd_data < key_ff) && (hi_ff < last_ff)) begin
               lo_in       = BOUND_W'(hi_ff);
               hi_in       = (hi_ff > (last_ff >> 1)) ? last_ff : ADDR_W'(hi_ff << 1);
               rd_req.en   = 1'b1;
               rd_req.addr = hi_in;
            end else begin
               mid_in      = mid_of(lo_ff, hi_ff);
               rd_req.en   = 1'b1;
               rd_req.addr = mid_in;
               state_in    = ST_BCHECK;
            end
         end
         ST_BCHECK: begin
            if (rd_data == key_ff) begin
               rsp_in.valid    = 1'b1;
               rsp_in.found    = 1'b1;
               rsp_in.position = POS_W'(mid_ff);
               state_in        = ST_IDLE;
            end else begin
               if (rd_data > key_ff) begin
                  if (mid_ff == '0) begin
                     stop = 1'b1;
                  end else begin
                     nhi = mid_ff - 1'b1;
                  end
               end else begin
                  nlo = BOUND_W'(mid_ff) + 1'b1;
               end
               if (stop || (nlo > BOUND_W'(nhi))) begin
                  rsp_in.valid = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  // The next midpoint is read in the same cycle, one probe per cycle.
                  lo_in       = nlo;
                  hi_in       = nhi;
                  mid_in      = mid_of(nlo, nhi);
                  rd_req.en   = 1'b1;
                  rd_req.addr = mid_in;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      mid_ff          <= mid_in;
      last_ff         <= last_in;
      key_ff          <= key_in;
      rsp_ff.found    <= rsp_in.found;
      rsp_ff.position <= rsp_in.position;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_ff.valid <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_ff.valid <= rsp_in.valid;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp  = rsp_ff;

endmodule

`default_nettype wire

>>> src/exponential_search_sorted_core.sv
// Exponential search core: a sorted store of signed words searched by galloping
// then bisection. An item is accepted when start is high and busy is low. A write
// item leaves busy low. A search item gives one result, held on the rsp_ ports
// for exactly one cycle with rsp_valid high; the receiver cannot stall it. With a
// count of zero the result follows in the cycle after acceptance and busy stays
// low. Otherwise the result is strobed as busy falls, and the next item can be
// taken while it is strobed. Galloping probes element 0 and then doubling upper
// bounds, about log2 of the count probes, and bisection about log2 of the final
// span. A full store of 1024 words needs at most 11 galloping and 10 bisection
// probes. The single read port of the store allows one probe per cycle.
// The store is not cleared after reset; only written entries may be searched.
// Depends on ess_pkg, ess_ram, ess_search and the macros header.
`default_nettype none
`include "exponential_search_sorted_core_macros.svh"

module exponential_search_sorted_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic               req_opcode,
   input  wire ess_pkg::index_type req_element_index,
   input  wire ess_pkg::word_type  req_element_value,
   input  wire ess_pkg::word_type  req_search_key,
   output logic                    rsp_valid,
   output logic                    rsp_found,
   output ess_pkg::pos_type        rsp_position,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire ess_pkg::count_type csr_wdata
);

   import ess_pkg::*;

   count_type  count_ff, count_in;
   logic       accept;
   logic       wr_en;
   logic       search_start;
   rd_req_type rd_req;
   rsp_type    rsp;
   logic [WORD_W-1:0] rd_raw;

   assign accept       = start && !busy;
   assign wr_en        = accept && (req_opcode == OP_WRITE)
                         && (32'(req_element_index) < 32'(STORE_DEPTH));
   assign search_start = accept && (req_opcode == OP_SEARCH);
   assign csr_ready    = !busy;
   assign count_in     = (csr_valid && csr_ready) ? csr_wdata : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_W'(1);
      end else begin
         count_ff <= count_in;
      end
   end

   ess_ram #(
      .WIDTH (WORD_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (ADDR_W'(req_element_index)),
      .wr_data    (req_element_value),
      .rd_en      (rd_req.en),
      .rd_addr    (rd_req.addr),
      .rd_data_ff (rd_raw)
   );

   ess_search u_search (
      .clock         (clock),
      .reset         (reset),
      .search_start  (search_start),
      .search_key    (req_search_key),
      .element_count (count_ff),
      .rd_data       ($signed(rd_raw)),
      .rd_req        (rd_req),
      .busy          (busy),
      .rsp           (rsp)
   );

   assign rsp_valid    = rsp.valid;
   assign rsp_found    = rsp.found;
   assign rsp_position = rsp.position;

   `ESS_ASSERT_SAME(a_miss_pos_zero, rsp_valid && !rsp_found, rsp_position == '0)
   `ESS_ASSERT_SAME(a_rsp_when_idle, rsp_valid, !busy)
   `ESS_ASSERT_NEXT(a_write_no_rsp, accept && (req_opcode == OP_WRITE), !rsp_valid && !busy)
   `ESS_ASSERT_NEXT(a_search_runs, search_start, busy || rsp_valid)

endmodule

`default_nettype wire
